>>> rtl/ccg_pkg.sv
// ============================================================================
// ccg_pkg
// Shared types, constants and helpers of the coprocessor cartridge glue.
// ============================================================================
package ccg_pkg;

   localparam int RAM_BYTES = 8192;
   localparam int ROM_BYTES = 32768;
   localparam int RAM_AW    = $clog2(RAM_BYTES);
   localparam int ROM_AW    = $clog2(ROM_BYTES);

   localparam int ACC_W     = 27;
   localparam int FREQ_W    = 21;
   localparam int JMP_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 21;

   localparam logic [ACC_W-1:0]  ACC_MAX     = {ACC_W{1'b1}};
   localparam logic [FREQ_W-1:0] FREQ_RESET  = 21'd985248;

   localparam logic [ACC_W-1:0]  RATE_BASE   = 27'd5000000;
   localparam logic [ACC_W-1:0]  RATE_JMP0   = 27'd10000000;
   localparam logic [ACC_W-1:0]  RATE_JMP1   = 27'd20000000;
   localparam logic [ACC_W-1:0]  RATE_JMP2   = 27'd30000000;
   localparam logic [ACC_W-1:0]  RATE_JMP3   = 27'd50000000;

   localparam logic [7:0] BYTE_ABSENT = 8'hff;

   localparam logic [CSR_IDX_W-1:0] CSR_JUMPER      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOST_FREQ   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_PRESENT = 2'd2;

   typedef enum logic [2:0] {
      OP_COP_READ   = 3'd0,
      OP_COP_WRITE  = 3'd1,
      OP_COP_IDLE   = 3'd2,
      OP_IO1_WRITE  = 3'd3,
      OP_IO2_WRITE  = 3'd4,
      OP_IO2_READ   = 3'd5,
      OP_HOST_TICK  = 3'd6,
      OP_ROM_LOAD   = 3'd7
   } op_type;

   typedef struct packed {
      logic [JMP_W-1:0]  jumper;
      logic [FREQ_W-1:0] host_freq;
      logic              rom_present;
   } cfg_type;

   typedef struct packed {
      logic step;
      logic cop_cycle;
      logic host_tick;
   } pace_type;

   // Coprocessor clock rate selected by the speed jumpers.
   function automatic logic [ACC_W-1:0] cop_rate(input logic [JMP_W-1:0] jmp);
      logic [ACC_W-1:0] r;
      r = RATE_BASE;
      if (jmp[0]) r = r + RATE_JMP0;
      if (jmp[1]) r = r + RATE_JMP1;
      if (jmp[2]) r = r + RATE_JMP2;
      if (jmp[3]) r = r + RATE_JMP3;
      return r;
   endfunction

endpackage

>>> rtl/coprocessor_cartridge_glue_top.sv
// ============================================================================
// coprocessor_cartridge_glue_top
// Glue of a coprocessor expansion card: memory decode, mailboxes, control.
// ============================================================================
// A request passes through the input register and then the response register.
// Throughput: one request per cycle unless the response side stalls or the RAM clear runs.
// Reset: synchronous; afterwards the work RAM is cleared one byte a cycle,
// every byte of it, and no request is taken during that pass.
// The program ROM is not cleared; configuration returns to its reset values.
module coprocessor_cartridge_glue_top (
   input  logic        clock,
   input  logic        reset,
   // Request: tdata = address[15:0], data[23:16]; tuser = operation[2:0].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [2:0]  req_tuser,
   // Response: tdata = read_data[7:0], host_nmi[8], coproc_nmi[9],
   // rom_bank[10], cart_lines[11], run_enable[12], zero[15:13].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // Configuration writes.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ccg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ccg_pkg::CSR_DAT_W-1:0] csr_data
);

   // ---------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------
   ccg_pkg::cfg_type cfg;

   ccg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------------
   // Request decode at the input. Memory reads and writes are issued at the
   // edge that accepts the request, so the read data is ready when the
   // request sits in the input register. Since each request either reads
   // or writes, a write followed by a read of the same byte sees the new
   // value.
   // ---------------------------------------------------------------------
   ccg_pkg::op_type req_op;
   logic [15:0]     req_addr;
   logic [7:0]      req_data;
   logic            req_fire;

   assign req_op   = ccg_pkg::op_type'(req_tuser);
   assign req_addr = req_tdata[15:0];
   assign req_data = req_tdata[23:16];
   assign req_fire = req_tvalid && req_tready;

   // Work RAM clearing pass after reset.
   logic                       clear_ff;
   logic [ccg_pkg::RAM_AW-1:0] clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
      end else if (clear_ff) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (&clear_cnt_ff) begin
            clear_ff <= 1'b0;
         end
      end
   end

   logic                       ram_sel;
   logic                       ram_we;
   logic                       ram_re;
   logic [ccg_pkg::RAM_AW-1:0] ram_waddr;
   logic [7:0]                 ram_wdata;
   logic [7:0]                 ram_q;
   logic                       rom_we;
   logic                       rom_re;
   logic [7:0]                 rom_q;

   // RAM occupies the low 8 KiB of the coprocessor map.
   assign ram_sel   = req_addr[15:13] == 3'b000;
   assign ram_we    = clear_ff || (req_fire && req_op == ccg_pkg::OP_COP_WRITE && ram_sel);
   assign ram_waddr = clear_ff ? clear_cnt_ff : req_addr[ccg_pkg::RAM_AW-1:0];
   assign ram_wdata = clear_ff ? 8'h00 : req_data;
   assign ram_re    = req_fire && req_op == ccg_pkg::OP_COP_READ && ram_sel;
   assign rom_we    = req_fire && req_op == ccg_pkg::OP_ROM_LOAD;
   assign rom_re    = req_fire && req_op == ccg_pkg::OP_COP_READ && req_addr[15];

   ccg_ram #(
      .WIDTH (8),
      .DEPTH (ccg_pkg::RAM_BYTES)
   ) u_work_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (req_addr[ccg_pkg::RAM_AW-1:0]),
      .rdata (ram_q)
   );

   ccg_ram #(
      .WIDTH (8),
      .DEPTH (ccg_pkg::ROM_BYTES)
   ) u_program_rom (
      .clock (clock),
      .we    (rom_we),
      .waddr (req_addr[ccg_pkg::ROM_AW-1:0]),
      .wdata (req_data),
      .re    (rom_re),
      .raddr (req_addr[ccg_pkg::ROM_AW-1:0]),
      .rdata (rom_q)
   );

   // ---------------------------------------------------------------------
   // Input register. The request retires into the response register when
   // that register is empty or being drained; the read ports are only
   // enabled on acceptance, so their data holds while a request stalls.
   // ---------------------------------------------------------------------
   logic            s1_valid_ff;
   ccg_pkg::op_type s1_op_ff;
   logic [15:0]     s1_addr_ff;
   logic [7:0]      s1_data_ff;
   logic            rsp_valid_ff;
   logic            advance;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clear_ff && (!s1_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_op;
         s1_addr_ff <= req_addr;
         s1_data_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------------
   // Mailboxes, interrupt flags and host control.
   // ---------------------------------------------------------------------
   logic [7:0] out_box_ff, out_box_in;
   logic [7:0] in_box_ff, in_box_in;
   logic       host_irq_ff, host_irq_in;
   logic       cop_irq_ff, cop_irq_in;
   logic [1:0] bank_ff, bank_in;
   logic       locked_ff, locked_in;
   logic [7:0] read_byte;
   logic       mbox_sel;
   logic       s1_ram_sel;

   // The mailbox window is any address with bits 14..8 all set.
   assign mbox_sel   = &s1_addr_ff[14:8];
   assign s1_ram_sel = s1_addr_ff[15:13] == 3'b000;

   always_comb begin
      out_box_in  = out_box_ff;
      in_box_in   = in_box_ff;
      host_irq_in = host_irq_ff;
      cop_irq_in  = cop_irq_ff;
      bank_in     = bank_ff;
      locked_in   = locked_ff;
      read_byte   = 8'h00;
      case (s1_op_ff)
         ccg_pkg::OP_COP_READ: begin
            if (s1_addr_ff[15]) begin
               read_byte = cfg.rom_present ? rom_q : ccg_pkg::BYTE_ABSENT;
            end else if (s1_ram_sel) begin
               read_byte = ram_q;
            end else if (mbox_sel) begin
               // Reading the inbound box releases the coprocessor NMI.
               read_byte  = in_box_ff;
               cop_irq_in = 1'b0;
            end
         end
         ccg_pkg::OP_COP_WRITE: begin
            // The outbound box is also reached from the ROM half of the map.
            if (!s1_ram_sel && mbox_sel) begin
               out_box_in  = s1_data_ff;
               host_irq_in = 1'b1;
            end
         end
         ccg_pkg::OP_IO1_WRITE: begin
            if (!locked_ff) begin
               bank_in   = s1_data_ff[1:0];
               locked_in = s1_data_ff[7];
            end
         end
         ccg_pkg::OP_IO2_WRITE: begin
            in_box_in  = s1_data_ff;
            cop_irq_in = 1'b1;
         end
         ccg_pkg::OP_IO2_READ: begin
            read_byte   = out_box_ff;
            host_irq_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_box_ff  <= '0;
         in_box_ff   <= '0;
         host_irq_ff <= 1'b0;
         cop_irq_ff  <= 1'b0;
         bank_ff     <= '0;
         locked_ff   <= 1'b0;
      end else if (advance) begin
         out_box_ff  <= out_box_in;
         in_box_ff   <= in_box_in;
         host_irq_ff <= host_irq_in;
         cop_irq_ff  <= cop_irq_in;
         bank_ff     <= bank_in;
         locked_ff   <= locked_in;
      end
   end

   // ---------------------------------------------------------------------
   // Rate accumulator. Every coprocessor bus cycle, idle ones included,
   // adds the host rate; a host tick takes the coprocessor rate away.
   // ---------------------------------------------------------------------
   ccg_pkg::pace_type pace;
   logic              run_enable;

   assign pace.step      = advance;
   assign pace.cop_cycle = s1_op_ff == ccg_pkg::OP_COP_READ
                        || s1_op_ff == ccg_pkg::OP_COP_WRITE
                        || s1_op_ff == ccg_pkg::OP_COP_IDLE;
   assign pace.host_tick = s1_op_ff == ccg_pkg::OP_HOST_TICK;

   ccg_pacer u_pacer (
      .clock      (clock),
      .reset      (reset),
      .host_freq  (cfg.host_freq),
      .jumper     (cfg.jumper),
      .pace       (pace),
      .run_enable (run_enable)
   );

   // ---------------------------------------------------------------------
   // Response register.
   // ---------------------------------------------------------------------
   logic [12:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {run_enable, bank_in[1], bank_in[0], cop_irq_in, host_irq_in,
                         read_byte};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

`ifndef SYNTHESIS
   // No request may enter while the work RAM is still being cleared.
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_tready)
      else $error("request accepted during RAM clearing");

   // A stalled request stays in the input register.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_op_ff) && $stable(s1_addr_ff))
      else $error("stalled request lost");

   // Once locked, the control byte only changes through reset.
   a_lock_sticks: assert property (@(posedge clock) disable iff (reset)
      locked_ff |=> locked_ff && $stable(bank_ff))
      else $error("locked control changed");

   // A host mailbox read reports the host NMI as dropped.
   a_io2_read_drops_nmi: assert property (@(posedge clock) disable iff (reset)
      advance && s1_op_ff == ccg_pkg::OP_IO2_READ |=> !host_irq_ff && !rsp_tdata[8])
      else $error("host NMI not dropped by IO2 read");
`endif

endmodule

>>> rtl/ccg_ram.sv
// ============================================================================
// ccg_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ============================================================================
module ccg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/ccg_csr.sv
// ============================================================================
// ccg_csr
// Configuration registers: speed jumpers, host clock rate, ROM present.
// ============================================================================
module ccg_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ccg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ccg_pkg::CSR_DAT_W-1:0]    csr_data,
   output ccg_pkg::cfg_type                 cfg
);

   ccg_pkg::cfg_type cfg_ff;
   logic             wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jumper      <= '0;
         cfg_ff.host_freq   <= ccg_pkg::FREQ_RESET;
         cfg_ff.rom_present <= 1'b0;
      end else if (wr) begin
         case (csr_index)
            ccg_pkg::CSR_JUMPER:      cfg_ff.jumper      <= csr_data[ccg_pkg::JMP_W-1:0];
            ccg_pkg::CSR_HOST_FREQ:   cfg_ff.host_freq   <= csr_data[ccg_pkg::FREQ_W-1:0];
            ccg_pkg::CSR_ROM_PRESENT: cfg_ff.rom_present <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/ccg_pacer.sv
// ============================================================================
// ccg_pacer
// Rate accumulator that paces the coprocessor against the host clock.
// ============================================================================
module ccg_pacer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ccg_pkg::FREQ_W-1:0]    host_freq,
   input  logic [ccg_pkg::JMP_W-1:0]     jumper,
   input  ccg_pkg::pace_type             pace,
   output logic                          run_enable
);

   logic [ccg_pkg::ACC_W-1:0] acc_ff;
   logic [ccg_pkg::ACC_W-1:0] acc_in;
   logic [ccg_pkg::ACC_W:0]   sum;
   logic [ccg_pkg::ACC_W-1:0] rate;

   assign rate = ccg_pkg::cop_rate(jumper);
   assign sum  = {1'b0, acc_ff} + {{(ccg_pkg::ACC_W + 1 - ccg_pkg::FREQ_W){1'b0}}, host_freq};

   always_comb begin
      acc_in = acc_ff;
      if (pace.cop_cycle) begin
         acc_in = sum[ccg_pkg::ACC_W] ? ccg_pkg::ACC_MAX : sum[ccg_pkg::ACC_W-1:0];
      end else if (pace.host_tick) begin
         acc_in = (acc_ff > rate) ? acc_ff - rate : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (pace.step) begin
         acc_ff <= acc_in;
      end
   end

   // Level seen by the item that is being retired this cycle.
   assign run_enable = acc_in < rate;

endmodule

>>> tb/coprocessor_cartridge_glue_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// coprocessor_cartridge_glue_top_tb
// Self-checking bench for the coprocessor cartridge glue. A table of directed
// requests is applied first, followed by phases of random bus traffic, with
// random pauses on the request side and on the response side. Each reply is
// compared, field by field, with a typed-in reply or with the reply computed
// by a bench-side model of the card.
// ============================================================================
module coprocessor_cartridge_glue_top_tb;

   // The work RAM is cleared after reset, and no handshake moves during that
   // pass. That pass is the longest quiet stretch of a correct run, so the
   // watchdog allows several times its length.
   localparam int STUCK_LIMIT    = 40000;
   localparam int ITEMS_PER_PASS = 144;
   localparam int RANDOM_PASSES  = 8;
   localparam int DRAIN_CYCLES   = 8;
   localparam int SHOWN_ERRORS   = 10;

   // Bits 14..8 of an address that selects a mailbox.
   localparam logic [6:0] MAILBOX_PAGE = 7'h7f;

   // Reply layout, identical to rsp_tdata[12:0], with the last field lowest.
   typedef struct packed {
      logic       run_enable;
      logic       cart_lines;
      logic       rom_bank;
      logic       coproc_nmi;
      logic       host_nmi;
      logic [7:0] read_data;
   } bus_reply_type;

   typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_type;

   // One row of the directed table: either a bus request or a register write.
   // A request row can carry a reply that is typed in by hand.
   typedef struct packed {
      row_kind_type                  kind;
      ccg_pkg::op_type               op;
      logic [15:0]                   address;
      logic [7:0]                    data;
      logic [ccg_pkg::CSR_IDX_W-1:0] reg_index;
      logic [ccg_pkg::CSR_DAT_W-1:0] reg_value;
      logic                          literal;
      bus_reply_type                 reply;
   } stim_row_type;

   // Every input of the block is known from time zero.
   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [23:0]                   req_tdata  = '0;   // address[15:0], data[23:16]
   logic [2:0]                    req_tuser  = '0;   // operation[2:0]
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [15:0]                   rsp_tdata;         // read_data[7:0], host_nmi[8],
                                                     // coproc_nmi[9], rom_bank[10],
                                                     // cart_lines[11], run_enable[12],
                                                     // zero[15:13]
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [ccg_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [ccg_pkg::CSR_DAT_W-1:0] csr_data   = '0;

   coprocessor_cartridge_glue_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Bench-side model of the card. It is advanced once per accepted request
   // and once per accepted register write, in the order they are accepted.
   // ---------------------------------------------------------------------
   bit   [7:0]                 ram_img [ccg_pkg::RAM_BYTES];   // zero after reset
   logic [7:0]                 rom_img [ccg_pkg::ROM_BYTES];
   bit                         rom_written [ccg_pkg::ROM_BYTES];
   logic [ccg_pkg::ROM_AW-1:0] rom_entries [$];          // ROM offsets loaded so far
   logic [7:0]                 out_box      = '0;
   logic [7:0]                 in_box       = '0;
   logic                       host_irq     = 1'b0;
   logic                       cop_irq      = 1'b0;
   logic [1:0]                 bank_lines   = '0;
   logic                       ctl_locked   = 1'b0;
   logic [ccg_pkg::ACC_W-1:0]  pace_acc     = '0;
   logic [ccg_pkg::JMP_W-1:0]  jumpers      = '0;
   logic [ccg_pkg::FREQ_W-1:0] host_freq    = ccg_pkg::FREQ_RESET;
   logic                       rom_on       = 1'b0;

   bus_reply_type predicted_replies [$];

   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned replies_seen  = 0;
   int unsigned reg_writes    = 0;
   int unsigned rom_hits      = 0;
   int unsigned mismatches    = 0;
   int unsigned stuck_cycles  = 0;

   // Coprocessor clock rate picked by the speed jumpers.
   function automatic logic [ccg_pkg::ACC_W-1:0] coproc_rate(
      input logic [ccg_pkg::JMP_W-1:0] j);
      return 27'd5_000_000 + (j[0] ? 27'd10_000_000 : 27'd0)
                           + (j[1] ? 27'd20_000_000 : 27'd0)
                           + (j[2] ? 27'd30_000_000 : 27'd0)
                           + (j[3] ? 27'd50_000_000 : 27'd0);
   endfunction

   // Applies one request to the model and returns the reply it must cause.
   function automatic bus_reply_type card_step(input ccg_pkg::op_type op,
                                               input logic [15:0] a,
                                               input logic [7:0] d);
      bus_reply_type             r;
      logic [ccg_pkg::ACC_W:0]   sum;
      logic [ccg_pkg::ACC_W-1:0] rate;
      r    = '0;
      rate = coproc_rate(jumpers);
      // Every coprocessor bus cycle feeds the pacing accumulator, which
      // sticks at its top value instead of wrapping.
      if (op == ccg_pkg::OP_COP_READ || op == ccg_pkg::OP_COP_WRITE
          || op == ccg_pkg::OP_COP_IDLE) begin
         sum      = {1'b0, pace_acc}
                  + {{(ccg_pkg::ACC_W + 1 - ccg_pkg::FREQ_W){1'b0}}, host_freq};
         pace_acc = (sum > {1'b0, ccg_pkg::ACC_MAX}) ? ccg_pkg::ACC_MAX
                                                     : sum[ccg_pkg::ACC_W-1:0];
      end
      case (op)
         ccg_pkg::OP_COP_READ: begin
            if (a[15]) begin
               r.read_data = rom_on ? rom_img[a[14:0]] : ccg_pkg::BYTE_ABSENT;
               rom_hits++;
            end else if (a[15:13] == 3'b000) begin
               r.read_data = ram_img[a[12:0]];
            end else if (a[14:8] == MAILBOX_PAGE) begin
               cop_irq     = 1'b0;
               r.read_data = in_box;
            end
         end
         ccg_pkg::OP_COP_WRITE: begin
            // The mailbox decode ignores bit 15, so 0xffxx reaches it too.
            if (a[15:13] == 3'b000) begin
               ram_img[a[12:0]] = d;
            end else if (a[14:8] == MAILBOX_PAGE) begin
               out_box  = d;
               host_irq = 1'b1;
            end
         end
         ccg_pkg::OP_IO1_WRITE: begin
            if (!ctl_locked) begin
               bank_lines = d[1:0];
               ctl_locked = d[7];
            end
         end
         ccg_pkg::OP_IO2_WRITE: begin
            in_box  = d;
            cop_irq = 1'b1;
         end
         ccg_pkg::OP_IO2_READ: begin
            host_irq    = 1'b0;
            r.read_data = out_box;
         end
         ccg_pkg::OP_HOST_TICK: begin
            pace_acc = (pace_acc > rate) ? pace_acc - rate : '0;
         end
         ccg_pkg::OP_ROM_LOAD: begin
            rom_img[a[14:0]] = d;
            if (!rom_written[a[14:0]]) begin
               rom_written[a[14:0]] = 1'b1;
               rom_entries.push_back(a[14:0]);
            end
         end
         default: ;
      endcase
      r.host_nmi   = host_irq;
      r.coproc_nmi = cop_irq;
      r.rom_bank   = bank_lines[0];
      r.cart_lines = bank_lines[1];
      r.run_enable = (pace_acc < rate);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Tasks are entered just after a rising edge.
   // ---------------------------------------------------------------------
   task automatic send_request(input ccg_pkg::op_type op, input logic [15:0] a,
                               input logic [7:0] d, input logic literal,
                               input bus_reply_type typed_reply);
      bus_reply_type r;
      int unsigned   gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {d, a};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      r = card_step(op, a, d);
      predicted_replies.push_back(literal ? typed_reply : r);
      // Idle cycles after the request; valid is only lowered when the gap
      // is real, so back-to-back requests keep it high.
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until the block holds no request, so that a register may change.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (predicted_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [ccg_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [ccg_pkg::CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      reg_writes++;
      case (idx)
         ccg_pkg::CSR_JUMPER:      jumpers   = val[ccg_pkg::JMP_W-1:0];
         ccg_pkg::CSR_HOST_FREQ:   host_freq = val[ccg_pkg::FREQ_W-1:0];
         ccg_pkg::CSR_ROM_PRESENT: rom_on    = val[0];
         default: ;
      endcase
      // One cycle with valid low keeps two writes from sharing an edge.
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random traffic. Most coprocessor accesses land on decoded areas, and
   // half of the RAM accesses crowd into a small window so reads find written bytes.
   task automatic send_random_request(input bit allow_lock);
      ccg_pkg::op_type op;
      logic [15:0]     a;
      logic [7:0]      d;
      logic [31:0]     rnd;
      int unsigned     pick;
      pick = $urandom_range(99);
      if      (pick < 28) op = ccg_pkg::OP_COP_READ;
      else if (pick < 48) op = ccg_pkg::OP_COP_WRITE;
      else if (pick < 56) op = ccg_pkg::OP_COP_IDLE;
      else if (pick < 62) op = ccg_pkg::OP_IO1_WRITE;
      else if (pick < 72) op = ccg_pkg::OP_IO2_WRITE;
      else if (pick < 82) op = ccg_pkg::OP_IO2_READ;
      else if (pick < 92) op = ccg_pkg::OP_HOST_TICK;
      else                op = ccg_pkg::OP_ROM_LOAD;
      rnd = $urandom;
      a   = rnd[15:0];
      d   = rnd[23:16];
      rnd = $urandom;
      if (op == ccg_pkg::OP_COP_READ || op == ccg_pkg::OP_COP_WRITE) begin
         pick = $urandom_range(9);
         if (pick < 4)
            a = {3'b000, rnd[0] ? {7'd0, rnd[6:1]} : rnd[13:1]};
         else if (pick < 6)
            a = {rnd[0], MAILBOX_PAGE, rnd[8:1]};
         else if (pick < 8)
            a = {1'b1, rnd[15:1]};
      end else if (op == ccg_pkg::OP_ROM_LOAD && rnd[0]) begin
         a = {rnd[1], 7'd0, rnd[9:2]};
      end
      // A ROM byte that was never loaded must not be read while the ROM is
      // marked present: such reads go to a loaded byte, or off the ROM.
      if (op == ccg_pkg::OP_COP_READ && a[15] && rom_on && !rom_written[a[14:0]]) begin
         if (rom_entries.size() == 0)
            a[15] = 1'b0;
         else
            a = {1'b1, rom_entries[$urandom_range(rom_entries.size() - 1)]};
      end
      // Setting bit 7 locks the control register until reset, and reset
      // happens only once; the lock is left to the last random pass.
      if (op == ccg_pkg::OP_IO1_WRITE && !allow_lock) d[7] = 1'b0;
      send_request(op, a, d, 1'b0, '0);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, and the reply check.
   // ---------------------------------------------------------------------
   task automatic note_mismatch(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
         $display("reply %0d %s: expected %0h, got %0h", replies_seen, what, want, got);
   endtask

   always @(posedge clock) begin : reply_check
      bus_reply_type got;
      bus_reply_type want;
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[12:0];
         replies_seen++;
         if (predicted_replies.size() == 0) begin
            note_mismatch("without a request", 16'h0, rsp_tdata);
         end else begin
            want = predicted_replies.pop_front();
            if (got.read_data != want.read_data)
               note_mismatch("read_data", 16'(want.read_data), 16'(got.read_data));
            if (got.host_nmi != want.host_nmi)
               note_mismatch("host_nmi", 16'(want.host_nmi), 16'(got.host_nmi));
            if (got.coproc_nmi != want.coproc_nmi)
               note_mismatch("coproc_nmi", 16'(want.coproc_nmi), 16'(got.coproc_nmi));
            if (got.rom_bank != want.rom_bank)
               note_mismatch("rom_bank", 16'(want.rom_bank), 16'(got.rom_bank));
            if (got.cart_lines != want.cart_lines)
               note_mismatch("cart_lines", 16'(want.cart_lines), 16'(got.cart_lines));
            if (got.run_enable != want.run_enable)
               note_mismatch("run_enable", 16'(want.run_enable), 16'(got.run_enable));
            if (rsp_tdata[15:13] != 3'b000)
               note_mismatch("spare bits", 16'h0, 16'(rsp_tdata[15:13]));
         end
      end
   end

   // The watchdog counts cycles in which no channel moves anything.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", stuck_cycles);
         $display("coprocessor_cartridge_glue_top: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Directed table constructors.
   // ---------------------------------------------------------------------
   function automatic stim_row_type req_row(input ccg_pkg::op_type op,
                                            input logic [15:0] a,
                                            input logic [7:0] d, input logic literal,
                                            input bus_reply_type reply);
      stim_row_type row;
      row         = '0;
      row.kind    = ROW_REQUEST;
      row.op      = op;
      row.address = a;
      row.data    = d;
      row.literal = literal;
      row.reply   = reply;
      return row;
   endfunction

   function automatic stim_row_type reg_row(input logic [ccg_pkg::CSR_IDX_W-1:0] idx,
                                            input logic [ccg_pkg::CSR_DAT_W-1:0] val);
      stim_row_type row;
      row           = '0;
      row.kind      = ROW_REGISTER;
      row.op        = ccg_pkg::OP_COP_IDLE;
      row.reg_index = idx;
      row.reg_value = val;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type directed_rows [$];
      stim_row_type row;
      int unsigned  directed_count;
      int unsigned  mode;

      // Typed-in replies are {run_enable, cart_lines, rom_bank, coproc_nmi,
      // host_nmi, read_data}. Right after reset the rate is 5 MHz and five
      // coprocessor cycles of the default host frequency stay below it.
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_READ,  16'h0000, 8'h00, 1'b1, 13'h1000));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_READ,  16'hffff, 8'h00, 1'b1, 13'h10ff));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_READ,  16'h7f00, 8'h00, 1'b1, 13'h1000));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_READ,  16'h2000, 8'h00, 1'b1, 13'h1000));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_WRITE, 16'h1fff, 8'ha5, 1'b1, 13'h1000));
      // From here on the accumulator passes the rate; the model decides.
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_READ,  16'h1fff, 8'h00, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_WRITE, 16'hff12, 8'h3c, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_WRITE, 16'h4000, 8'h77, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_IO2_READ,  16'hffff, 8'hff, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_IO2_WRITE, 16'h0000, 8'hff, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_READ,  16'h7fff, 8'hff, 1'b0, '0));
      // Two host ticks: the second one runs into the floor at zero.
      directed_rows.push_back(req_row(ccg_pkg::OP_HOST_TICK, 16'hffff, 8'hff, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_HOST_TICK, 16'h0000, 8'h00, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_IDLE,  16'hffff, 8'hff, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_IO1_WRITE, 16'hffff, 8'h03, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_IO1_WRITE, 16'h0000, 8'h7d, 1'b0, '0));
      // ROM loads at both ends; bit 15 of the load address is ignored.
      directed_rows.push_back(req_row(ccg_pkg::OP_ROM_LOAD,  16'h0000, 8'h5a, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_ROM_LOAD,  16'hffff, 8'hc3, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_READ,  16'h8000, 8'h00, 1'b0, '0));
      directed_rows.push_back(reg_row(ccg_pkg::CSR_ROM_PRESENT, 21'd1));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_READ,  16'h8000, 8'h00, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_READ,  16'hffff, 8'h00, 1'b0, '0));
      // Fastest pacing against the highest rate, then the slowest of each.
      directed_rows.push_back(reg_row(ccg_pkg::CSR_HOST_FREQ, 21'd2_000_000));
      directed_rows.push_back(reg_row(ccg_pkg::CSR_JUMPER, 21'd15));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_IDLE,  16'h0000, 8'h00, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_HOST_TICK, 16'h0000, 8'h00, 1'b0, '0));
      directed_rows.push_back(reg_row(ccg_pkg::CSR_JUMPER, 21'd0));
      directed_rows.push_back(reg_row(ccg_pkg::CSR_HOST_FREQ, 21'd1));
      directed_rows.push_back(req_row(ccg_pkg::OP_IO2_WRITE, 16'hffff, 8'h00, 1'b0, '0));
      directed_rows.push_back(req_row(ccg_pkg::OP_COP_READ,  16'hff55, 8'h00, 1'b0, '0));

      // Synchronous reset comes first. The work RAM clear that
      // follows simply shows up as req_tready staying low.
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The directed part runs without idling on either side.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_REGISTER) begin
            settle();
            write_register(row.reg_index, row.reg_value);
         end else begin
            send_request(row.op, row.address, row.data, row.literal, row.reply);
         end
      end
      directed_count = requests_sent;

      // Random passes. The first two use the extremes of every register,
      // the rest random settings; the idling pattern rotates through no
      // idling, an idle sender, a stalling receiver, and both at once.
      for (int p = 0; p < RANDOM_PASSES; p++) begin
         settle();
         mode = p % 4;
         req_idle_pct  = (mode == 1) ? 73 : (mode == 3) ? 18 : 0;
         rsp_stall_pct = (mode == 2) ? 73 : (mode == 3) ? 18 : 0;
         if (p == 0) begin
            write_register(ccg_pkg::CSR_JUMPER, 21'd15);
            write_register(ccg_pkg::CSR_HOST_FREQ, 21'd2_000_000);
            write_register(ccg_pkg::CSR_ROM_PRESENT, 21'd1);
         end else if (p == 1) begin
            write_register(ccg_pkg::CSR_JUMPER, 21'd0);
            write_register(ccg_pkg::CSR_HOST_FREQ, 21'd1);
            write_register(ccg_pkg::CSR_ROM_PRESENT, 21'd0);
         end else begin
            write_register(ccg_pkg::CSR_JUMPER, 21'($urandom_range(15)));
            write_register(ccg_pkg::CSR_HOST_FREQ, 21'($urandom_range(1) ?
                           $urandom_range(2_000_000, 400_000) :
                           $urandom_range(2_000_000, 1)));
            write_register(ccg_pkg::CSR_ROM_PRESENT, 21'($urandom_range(1)));
         end
         for (int n = 0; n < ITEMS_PER_PASS; n++)
            send_random_request(p == RANDOM_PASSES - 1);
      end

      // Let the last replies come home, then idle for DRAIN_CYCLES so that the
      // block can show any reply that nobody asked for.
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests (%0d directed) and %0d register writes in %0d passes",
               requests_sent, directed_count, reg_writes, RANDOM_PASSES + 1);
      $display("replies checked %0d, ROM-area reads %0d, ROM bytes loaded %0d, mismatches %0d",
               replies_seen, rom_hits, rom_entries.size(), mismatches);
      if (mismatches == 0 && predicted_replies.size() == 0)
         $display("coprocessor_cartridge_glue_top: match");
      else
         $display("coprocessor_cartridge_glue_top: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
rtl/ccg_pkg.sv
rtl/ccg_ram.sv
rtl/ccg_csr.sv
rtl/ccg_pacer.sv
rtl/coprocessor_cartridge_glue_top.sv
tb/coprocessor_cartridge_glue_top_tb.sv
